>>> hw/rtl/stack_machine_step_assert.svh
// Assertion macros of the stack machine step RTL, included by the back end
`ifndef STACK_MACHINE_STEP_ASSERT_SVH
`define STACK_MACHINE_STEP_ASSERT_SVH

// same-cycle implication
`define SMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SMP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/smp_pkg.sv
// Types and constants of the stack machine step
package smp_pkg;

    localparam logic [4:0] OP_START  = 5'd0;
    localparam logic [4:0] OP_PUSH   = 5'd1;
    localparam logic [4:0] OP_LDREQ  = 5'd2;
    localparam logic [4:0] OP_LDRET  = 5'd3;
    localparam logic [4:0] OP_ADD    = 5'd4;
    localparam logic [4:0] OP_SUB    = 5'd5;
    localparam logic [4:0] OP_MUL    = 5'd6;
    localparam logic [4:0] OP_DIV    = 5'd7;
    localparam logic [4:0] OP_MOD    = 5'd8;
    localparam logic [4:0] OP_AND    = 5'd9;
    localparam logic [4:0] OP_OR     = 5'd10;
    localparam logic [4:0] OP_XOR    = 5'd11;
    localparam logic [4:0] OP_LAND   = 5'd12;
    localparam logic [4:0] OP_LOR    = 5'd13;
    localparam logic [4:0] OP_EQ     = 5'd14;
    localparam logic [4:0] OP_NE     = 5'd15;
    localparam logic [4:0] OP_GT     = 5'd16;
    localparam logic [4:0] OP_GE     = 5'd17;
    localparam logic [4:0] OP_LT     = 5'd18;
    localparam logic [4:0] OP_LE     = 5'd19;
    localparam logic [4:0] OP_COPY   = 5'd20;
    localparam logic [4:0] OP_POP    = 5'd21;
    localparam logic [4:0] OP_JMP    = 5'd22;
    localparam logic [4:0] OP_CJMP   = 5'd23;
    localparam logic [4:0] OP_OUTDEC = 5'd24;
    localparam logic [4:0] OP_OUTHEX = 5'd25;
    localparam logic [4:0] OP_OUTSTR = 5'd26;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_END   = 3'd1;
    localparam logic [2:0] ST_FAIL  = 3'd2;
    localparam logic [2:0] ST_LIMIT = 3'd3;
    localparam logic [2:0] ST_OVER  = 3'd4;
    localparam logic [2:0] ST_IGN   = 3'd5;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DEC  = 2'd1;
    localparam logic [1:0] KIND_HEX  = 2'd2;
    localparam logic [1:0] KIND_STR  = 2'd3;

    localparam logic [1:0] CFG_ILIM = 2'd0;
    localparam logic [1:0] CFG_SLIM = 2'd1;
    localparam logic [1:0] CFG_PLEN = 2'd2;

    localparam logic [15:0] ILIM_RESET = 16'd256;
    localparam logic [15:0] SLIM_RESET = 16'd1024;

    typedef enum logic [3:0] {
        CLS_START, CLS_PUSH, CLS_LDREQ, CLS_LDRET, CLS_ALU, CLS_MULDIV, CLS_COPY,
        CLS_POP, CLS_JMP, CLS_CJMP, CLS_OUTV, CLS_OUTS, CLS_BAD
    } t_cls;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_RB, S_RA, S_EXE, S_MD
    } t_st;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [63:0] immediate;
        logic [63:0] memory_word;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] next_pc;
        logic        load_request;
        logic [63:0] load_address;
        logic [1:0]  output_kind;
        logic [63:0] output_value;
        logic [15:0] output_length;
        logic        output_truncated;
        logic [8:0]  stack_count;
    } t_out;

    typedef struct packed {
        t_cls        cls;
        logic [4:0]  op;
        logic [63:0] imm;
        logic [63:0] mem;
    } t_dec;

    typedef struct packed {
        logic [15:0] ilim;
        logic [15:0] slim;
        logic [12:0] plen;
    } t_cfg;

endpackage

>>> hw/rtl/stack_machine_step.sv
// Top level of the stack machine step: config registers, front, back, result queue
//
// channel  direction  handshake               word
// input    in         push / full             i_in   (opcode, immediate, memory_word)
// result   out        pop / empty             o_out  (status .. stack_count)
// config   in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// In the back end a word passes through dequeue, decode, up to two stack memory reads
// and, where needed, execute; multiply, divide and modulo then iterate in the radix-2 unit.
// Synchronous active-low reset; the stack memory needs no clearing pass.
// A two-entry queue buffers input words; a two-entry queue holds results while pop is low.
module stack_machine_step #(
    parameter int STACK_DEPTH  = 256,
    parameter int PROGRAM_SIZE = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  smp_pkg::t_in   i_in,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output smp_pkg::t_out  o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data
);
    smp_pkg::t_cfg r_cfg;
    smp_pkg::t_dec w_q_data;
    smp_pkg::t_out w_res;
    logic          w_q_empty, w_q_pop, w_out_full, w_out_wr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ilim <= smp_pkg::ILIM_RESET;
            r_cfg.slim <= smp_pkg::SLIM_RESET;
            r_cfg.plen <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                smp_pkg::CFG_ILIM: r_cfg.ilim <= i_cfg_data;
                smp_pkg::CFG_SLIM: r_cfg.slim <= i_cfg_data;
                smp_pkg::CFG_PLEN: r_cfg.plen <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    smp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_in    (i_in),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_dec   (w_q_data)
    );

    smp_back #(.STACK_DEPTH(STACK_DEPTH), .PROGRAM_SIZE(PROGRAM_SIZE)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_q_data),
        .o_q_pop    (w_q_pop),
        .i_out_full (w_out_full),
        .o_out_wr   (w_out_wr),
        .o_out      (w_res)
    );

    smp_fifo #(.W($bits(smp_pkg::t_out)), .DEPTH(2)) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_out_wr),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_data  (o_out)
    );
endmodule

>>> hw/rtl/smp_fifo.sv
// Small word queue with fill count
module smp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_rd,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_comb begin
        n_wp  = w_wr ? ((r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1)) : r_wp;
        n_rp  = w_rd ? ((r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1)) : r_rp;
        n_cnt = r_cnt + CW'(w_wr) - CW'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

>>> hw/rtl/smp_muldiv.sv
// Radix-2 multiply, divide and modulo unit
module smp_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_div,
    input  logic        i_rem,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_result
);
    logic        r_busy, r_done, r_div, r_rem;
    logic [5:0]  r_cnt;
    logic [63:0] r_x, r_y, n_x, n_y;
    logic [64:0] r_acc, n_acc;
    logic [64:0] w_sh, w_diff;

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = (r_div && !r_rem) ? r_x : r_acc[63:0];

    always_comb begin
        w_sh   = {r_acc[63:0], r_x[63]};
        w_diff = w_sh - {1'b0, r_y};
        if (r_div) begin
            n_acc = w_diff[64] ? w_sh : w_diff;
            n_x   = {r_x[62:0], !w_diff[64]};
            n_y   = r_y;
        end else begin
            n_acc = r_y[0] ? {1'b0, r_acc[63:0] + r_x} : r_acc;
            n_x   = {r_x[62:0], 1'b0};
            n_y   = {1'b0, r_y[63:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_rem <= i_rem;
            r_x   <= i_a;
            r_y   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_acc <= n_acc;
        end
    end
endmodule

>>> hw/rtl/smp_front.sv
// Front end: accept words, classify opcodes, queue them for execution
module smp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  smp_pkg::t_in   i_in,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output smp_pkg::t_dec  o_dec
);
    smp_pkg::t_dec w_dec;

    function automatic smp_pkg::t_cls classify(input logic [4:0] op);
        smp_pkg::t_cls c;
        if (op == smp_pkg::OP_START) c = smp_pkg::CLS_START;
        else if (op == smp_pkg::OP_PUSH) c = smp_pkg::CLS_PUSH;
        else if (op == smp_pkg::OP_LDREQ) c = smp_pkg::CLS_LDREQ;
        else if (op == smp_pkg::OP_LDRET) c = smp_pkg::CLS_LDRET;
        else if (op == smp_pkg::OP_MUL || op == smp_pkg::OP_DIV || op == smp_pkg::OP_MOD)
            c = smp_pkg::CLS_MULDIV;
        else if (op >= smp_pkg::OP_ADD && op <= smp_pkg::OP_LE) c = smp_pkg::CLS_ALU;
        else if (op == smp_pkg::OP_COPY) c = smp_pkg::CLS_COPY;
        else if (op == smp_pkg::OP_POP) c = smp_pkg::CLS_POP;
        else if (op == smp_pkg::OP_JMP) c = smp_pkg::CLS_JMP;
        else if (op == smp_pkg::OP_CJMP) c = smp_pkg::CLS_CJMP;
        else if (op == smp_pkg::OP_OUTDEC || op == smp_pkg::OP_OUTHEX) c = smp_pkg::CLS_OUTV;
        else if (op == smp_pkg::OP_OUTSTR) c = smp_pkg::CLS_OUTS;
        else c = smp_pkg::CLS_BAD;
        return c;
    endfunction

    always_comb begin
        w_dec.cls = classify(i_in.opcode);
        w_dec.op  = i_in.opcode;
        w_dec.imm = i_in.immediate;
        w_dec.mem = i_in.memory_word;
    end

    smp_fifo #(.W($bits(smp_pkg::t_dec)), .DEPTH(2)) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_data  (w_dec),
        .o_full  (o_full),
        .i_rd    (i_pop),
        .o_empty (o_empty),
        .o_data  (o_dec)
    );
endmodule

>>> hw/rtl/smp_back.sv
// Back end: stack memory, machine state and instruction sequencer
`include "stack_machine_step_assert.svh"
module smp_back #(
    parameter int STACK_DEPTH  = 256,
    parameter int PROGRAM_SIZE = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  smp_pkg::t_cfg  i_cfg,
    input  logic           i_q_empty,
    input  smp_pkg::t_dec  i_q_data,
    output logic           o_q_pop,
    input  logic           i_out_full,
    output logic           o_out_wr,
    output smp_pkg::t_out  o_out
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    smp_pkg::t_st  r_st, n_st;
    smp_pkg::t_dec r_it;
    logic [63:0]   r_mem [STACK_DEPTH];
    logic [63:0]   r_rdata, r_a, r_b, n_a, n_b, r_last, n_last;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0]   r_pc, n_pc, jmp;
    logic [15:0]   r_exec, n_exec;
    logic          r_halt, n_halt, r_await, n_await;
    logic          rd_en, wr_en, dec_rd, need_a, fin, done, chk, psh;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [63:0]   pv;
    logic [2:0]    st;
    logic          w_md_start, w_md_busy, w_md_done, w_isdiv;
    logic [63:0]   w_md_res;
    smp_pkg::t_out res;

    function automatic logic [2:0] bounds(input logic [31:0] pc, input logic [15:0] ex,
                                          input smp_pkg::t_cfg cfg);
        logic [31:0] len;
        len = (32'(cfg.plen) > 32'(PROGRAM_SIZE)) ? 32'(PROGRAM_SIZE) : 32'(cfg.plen);
        if (pc >= len) return smp_pkg::ST_END;
        if (ex >= cfg.ilim) return smp_pkg::ST_LIMIT;
        return smp_pkg::ST_RUN;
    endfunction

    function automatic logic [63:0] alu(input logic [4:0] op, input logic [63:0] a,
                                        input logic [63:0] b);
        logic [63:0] r;
        unique case (op)
            smp_pkg::OP_ADD:  r = a + b;
            smp_pkg::OP_SUB:  r = a - b;
            smp_pkg::OP_AND:  r = a & b;
            smp_pkg::OP_OR:   r = a | b;
            smp_pkg::OP_XOR:  r = a ^ b;
            smp_pkg::OP_LAND: r = 64'((a != '0) && (b != '0));
            smp_pkg::OP_LOR:  r = 64'((a != '0) || (b != '0));
            smp_pkg::OP_EQ:   r = 64'(a == b);
            smp_pkg::OP_NE:   r = 64'(a != b);
            smp_pkg::OP_GT:   r = 64'(a > b);
            smp_pkg::OP_GE:   r = 64'(a >= b);
            smp_pkg::OP_LT:   r = 64'(a < b);
            default:          r = 64'(a <= b);
        endcase
        return r;
    endfunction

    assign o_q_pop = (r_st == smp_pkg::S_IDLE) && !i_q_empty && !i_out_full;
    assign w_isdiv = (r_it.op == smp_pkg::OP_DIV) || (r_it.op == smp_pkg::OP_MOD);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            smp_pkg::S_IDLE: if (o_q_pop) n_st = smp_pkg::S_DEC;
            smp_pkg::S_DEC:  n_st = dec_rd ? smp_pkg::S_RB : smp_pkg::S_IDLE;
            smp_pkg::S_RB:   n_st = need_a ? smp_pkg::S_RA : smp_pkg::S_EXE;
            smp_pkg::S_RA:   n_st = smp_pkg::S_EXE;
            smp_pkg::S_EXE:  n_st = w_md_start ? smp_pkg::S_MD : smp_pkg::S_IDLE;
            smp_pkg::S_MD:   if (w_md_done) n_st = smp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;   n_pc = r_pc;     n_last = r_last;  n_exec = r_exec;
        n_halt = r_halt; n_await = r_await; n_a = r_a;      n_b = r_b;
        fin = 1'b0; done = 1'b0; chk = 1'b0; psh = 1'b0; pv = '0;
        st = smp_pkg::ST_RUN; jmp = 32'd1;
        rd_en = 1'b0; rd_addr = AW'(r_cnt - CW'(1)); dec_rd = 1'b0; need_a = 1'b0;
        w_md_start = 1'b0; wr_en = 1'b0; wr_addr = '0;
        res = '0;
        unique case (r_st)
            smp_pkg::S_DEC: begin
                if (r_it.cls == smp_pkg::CLS_START) begin
                    n_cnt = '0; n_pc = '0; n_last = '0; n_exec = '0;
                    n_await = 1'b0; n_halt = 1'b0;
                    psh = 1'b1; pv = r_it.imm; fin = 1'b1; chk = 1'b1;
                end else if (r_halt) begin
                    st = smp_pkg::ST_IGN; fin = 1'b1;
                end else if (bounds(r_pc, r_exec, i_cfg) != smp_pkg::ST_RUN) begin
                    st = bounds(r_pc, r_exec, i_cfg); n_halt = 1'b1; fin = 1'b1;
                end else if (r_await) begin
                    fin = 1'b1;
                    if (r_it.cls == smp_pkg::CLS_LDRET) begin
                        n_await = 1'b0; psh = 1'b1; pv = r_it.mem; done = 1'b1;
                    end else begin
                        st = smp_pkg::ST_FAIL;
                    end
                end else begin
                    unique case (r_it.cls)
                        smp_pkg::CLS_PUSH: begin
                            fin = 1'b1; psh = 1'b1; pv = r_it.imm; done = 1'b1;
                        end
                        smp_pkg::CLS_LDREQ, smp_pkg::CLS_OUTV: begin
                            if (r_cnt == '0) begin
                                fin = 1'b1; st = smp_pkg::ST_FAIL;
                            end else begin
                                dec_rd = 1'b1;
                            end
                        end
                        smp_pkg::CLS_ALU, smp_pkg::CLS_MULDIV, smp_pkg::CLS_OUTS: begin
                            if (r_cnt < CW'(2)) begin
                                fin = 1'b1; st = smp_pkg::ST_FAIL;
                            end else begin
                                dec_rd = 1'b1;
                            end
                        end
                        smp_pkg::CLS_COPY: begin
                            if (64'(r_cnt) <= r_it.imm) begin
                                fin = 1'b1; st = smp_pkg::ST_FAIL;
                            end else begin
                                dec_rd = 1'b1;
                                rd_addr = AW'(r_cnt - CW'(1) - CW'(r_it.imm[AW-1:0]));
                            end
                        end
                        smp_pkg::CLS_POP: begin
                            if (64'(r_cnt) < r_it.imm) begin
                                fin = 1'b1; st = smp_pkg::ST_FAIL;
                            end else if (r_cnt == '0) begin
                                n_last = '0; fin = 1'b1; done = 1'b1;
                            end else begin
                                dec_rd = 1'b1;
                            end
                        end
                        smp_pkg::CLS_JMP: begin
                            fin = 1'b1; done = 1'b1; jmp = r_it.imm[31:0] + 32'd1;
                        end
                        smp_pkg::CLS_CJMP: begin
                            fin = 1'b1; done = 1'b1;
                            if (r_last != '0) jmp = r_it.imm[31:0] + 32'd1;
                        end
                        default: begin
                            fin = 1'b1; st = smp_pkg::ST_FAIL;
                        end
                    endcase
                end
                rd_en = dec_rd;
            end
            smp_pkg::S_RB: begin
                n_b = r_rdata;
                need_a = (r_it.cls == smp_pkg::CLS_ALU) || (r_it.cls == smp_pkg::CLS_MULDIV)
                      || (r_it.cls == smp_pkg::CLS_OUTS);
                rd_en = need_a;
                rd_addr = AW'(r_cnt - CW'(2));
            end
            smp_pkg::S_RA: begin
                n_a = r_rdata;
            end
            smp_pkg::S_EXE: begin
                fin = 1'b1;
                unique case (r_it.cls)
                    smp_pkg::CLS_LDREQ: begin
                        res.load_request = 1'b1; res.load_address = r_b; n_await = 1'b1;
                    end
                    smp_pkg::CLS_OUTV: begin
                        res.output_kind = (r_it.op == smp_pkg::OP_OUTDEC) ?
                                          smp_pkg::KIND_DEC : smp_pkg::KIND_HEX;
                        res.output_value = r_b; done = 1'b1;
                    end
                    smp_pkg::CLS_OUTS: begin
                        res.output_kind = smp_pkg::KIND_STR;
                        res.output_value = r_a;
                        res.output_truncated = (r_b > 64'(i_cfg.slim));
                        res.output_length = res.output_truncated ? i_cfg.slim : r_b[15:0];
                        done = 1'b1;
                    end
                    smp_pkg::CLS_COPY: begin
                        psh = 1'b1; pv = r_b; done = 1'b1;
                    end
                    smp_pkg::CLS_POP: begin
                        n_last = r_b; n_cnt = r_cnt - CW'(r_it.imm[CW-1:0]); done = 1'b1;
                    end
                    smp_pkg::CLS_ALU: begin
                        psh = 1'b1; pv = alu(r_it.op, r_a, r_b); done = 1'b1;
                    end
                    default: begin
                        if (w_isdiv && (r_b == '0)) begin
                            st = smp_pkg::ST_FAIL;
                        end else begin
                            w_md_start = 1'b1; fin = 1'b0;
                        end
                    end
                endcase
            end
            smp_pkg::S_MD: begin
                if (w_md_done) begin
                    fin = 1'b1; psh = 1'b1; pv = w_md_res; done = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (fin) begin
            if (psh) begin
                if (n_cnt >= CW'(STACK_DEPTH)) begin
                    st = smp_pkg::ST_OVER; done = 1'b0;
                end else begin
                    wr_en = 1'b1; wr_addr = AW'(n_cnt); n_cnt = n_cnt + CW'(1);
                end
            end
            if (st == smp_pkg::ST_FAIL || st == smp_pkg::ST_OVER) n_halt = 1'b1;
            if (done) begin
                n_pc = n_pc + jmp; n_exec = n_exec + 16'd1;
            end
            if (done || chk) begin
                st = bounds(n_pc, n_exec, i_cfg);
                if (st != smp_pkg::ST_RUN) n_halt = 1'b1;
            end
        end
        res.status      = st;
        res.next_pc     = n_pc[11:0];
        res.stack_count = 9'(32'(n_cnt));
    end

    assign o_out_wr = fin;
    assign o_out    = res;

    smp_muldiv u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_md_start),
        .i_div    (w_isdiv),
        .i_rem    (r_it.op == smp_pkg::OP_MOD),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_busy   (w_md_busy),
        .o_done   (w_md_done),
        .o_result (w_md_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= smp_pkg::S_IDLE;
            r_cnt   <= '0;
            r_pc    <= '0;
            r_last  <= '0;
            r_exec  <= '0;
            r_halt  <= 1'b1;
            r_await <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_cnt   <= n_cnt;
            r_pc    <= n_pc;
            r_last  <= n_last;
            r_exec  <= n_exec;
            r_halt  <= n_halt;
            r_await <= n_await;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_it <= i_q_data;
        r_a <= n_a;
        r_b <= n_b;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= pv;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    `SMP_ASSERT_IMP(a_out_room, i_clk, i_rst_n, o_out_wr, !i_out_full)
    `SMP_ASSERT_IMP(a_md_free, i_clk, i_rst_n, w_md_start, !w_md_busy)
    `SMP_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(STACK_DEPTH))
    `SMP_ASSERT_NXT(a_md_ret, i_clk, i_rst_n, w_md_done, r_st == smp_pkg::S_IDLE)
endmodule

>>> tb/sv/tb_stack_machine_step.sv
// Self-checking testbench of the stack machine step: directed and random programs
module tb_stack_machine_step;

    class smp_scoreboard;
        logic [63:0]   stk [256];
        int            entries;
        logic [31:0]   pc;
        logic [63:0]   last_pop;
        int            executed;
        bit            halted;
        bit            await_load;
        logic [15:0]   ilim;
        logic [15:0]   slim;
        logic [12:0]   plen;
        smp_pkg::t_out pending [$];

        function new();
            ilim = smp_pkg::ILIM_RESET;
            slim = smp_pkg::SLIM_RESET;
            plen = '0;
            entries = 0;
            pc = '0;
            last_pop = '0;
            executed = 0;
            halted = 1'b1;
            await_load = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                smp_pkg::CFG_ILIM: ilim = data;
                smp_pkg::CFG_SLIM: slim = data;
                smp_pkg::CFG_PLEN: plen = data[12:0];
                default: ;
            endcase
        endfunction

        function logic [2:0] bounds();
            int len;
            len = (plen > 13'd4096) ? 4096 : int'(plen);
            if (pc >= len) return smp_pkg::ST_END;
            if (executed >= int'(ilim)) return smp_pkg::ST_LIMIT;
            return smp_pkg::ST_RUN;
        endfunction

        function logic [63:0] top(int d);
            return stk[(entries - 1 - d) % 256];
        endfunction

        function bit push_word(logic [63:0] v);
            if (entries >= 256) return 1'b0;
            stk[entries] = v;
            entries++;
            return 1'b1;
        endfunction

        function logic [63:0] alu(logic [4:0] op, logic [63:0] a, logic [63:0] b);
            case (op)
                smp_pkg::OP_ADD:  return a + b;
                smp_pkg::OP_SUB:  return a - b;
                smp_pkg::OP_MUL:  return a * b;
                smp_pkg::OP_DIV:  return a / b;
                smp_pkg::OP_MOD:  return a % b;
                smp_pkg::OP_AND:  return a & b;
                smp_pkg::OP_OR:   return a | b;
                smp_pkg::OP_XOR:  return a ^ b;
                smp_pkg::OP_LAND: return 64'((a != 0) && (b != 0));
                smp_pkg::OP_LOR:  return 64'((a != 0) || (b != 0));
                smp_pkg::OP_EQ:   return 64'(a == b);
                smp_pkg::OP_NE:   return 64'(a != b);
                smp_pkg::OP_GT:   return 64'(a > b);
                smp_pkg::OP_GE:   return 64'(a >= b);
                smp_pkg::OP_LT:   return 64'(a < b);
                default:          return 64'(a <= b);
            endcase
        endfunction

        function void note(smp_pkg::t_in it);
            smp_pkg::t_out r;
            logic [2:0]    st;
            bit            done;
            logic [31:0]   jump;
            logic [63:0]   a;
            logic [63:0]   b;
            logic [4:0]    op;
            r = '0;
            st = smp_pkg::ST_RUN;
            done = 1'b0;
            jump = 32'd1;
            op = it.opcode;
            if (op == smp_pkg::OP_START) begin
                entries = 0;
                pc = '0;
                last_pop = '0;
                executed = 0;
                await_load = 1'b0;
                halted = 1'b0;
                void'(push_word(it.immediate));
                st = bounds();
                if (st != smp_pkg::ST_RUN) halted = 1'b1;
            end else if (halted) begin
                st = smp_pkg::ST_IGN;
            end else begin
                st = bounds();
                if (st != smp_pkg::ST_RUN) begin
                    halted = 1'b1;
                end else if (await_load) begin
                    if (op == smp_pkg::OP_LDRET) begin
                        await_load = 1'b0;
                        if (push_word(it.memory_word)) done = 1'b1;
                        else st = smp_pkg::ST_OVER;
                    end else begin
                        st = smp_pkg::ST_FAIL;
                    end
                end else if (op == smp_pkg::OP_PUSH) begin
                    if (push_word(it.immediate)) done = 1'b1;
                    else st = smp_pkg::ST_OVER;
                end else if (op == smp_pkg::OP_LDREQ) begin
                    if (entries == 0) begin
                        st = smp_pkg::ST_FAIL;
                    end else begin
                        r.load_request = 1'b1;
                        r.load_address = top(0);
                        await_load = 1'b1;
                    end
                end else if (op >= smp_pkg::OP_ADD && op <= smp_pkg::OP_LE) begin
                    if (entries < 2) begin
                        st = smp_pkg::ST_FAIL;
                    end else begin
                        a = top(1);
                        b = top(0);
                        if ((op == smp_pkg::OP_DIV || op == smp_pkg::OP_MOD) && b == 0)
                            st = smp_pkg::ST_FAIL;
                        else if (push_word(alu(op, a, b))) done = 1'b1;
                        else st = smp_pkg::ST_OVER;
                    end
                end else if (op == smp_pkg::OP_COPY) begin
                    if (64'(entries) <= it.immediate) st = smp_pkg::ST_FAIL;
                    else if (push_word(top(int'(it.immediate[8:0])))) done = 1'b1;
                    else st = smp_pkg::ST_OVER;
                end else if (op == smp_pkg::OP_POP) begin
                    if (64'(entries) < it.immediate) begin
                        st = smp_pkg::ST_FAIL;
                    end else begin
                        last_pop = (entries != 0) ? top(0) : 64'd0;
                        entries -= int'(it.immediate[8:0]);
                        done = 1'b1;
                    end
                end else if (op == smp_pkg::OP_JMP || op == smp_pkg::OP_CJMP) begin
                    if (op == smp_pkg::OP_JMP || last_pop != 0)
                        jump = it.immediate[31:0] + 32'd1;
                    done = 1'b1;
                end else if (op == smp_pkg::OP_OUTDEC || op == smp_pkg::OP_OUTHEX) begin
                    if (entries == 0) begin
                        st = smp_pkg::ST_FAIL;
                    end else begin
                        r.output_kind = (op == smp_pkg::OP_OUTDEC) ? smp_pkg::KIND_DEC
                                                                  : smp_pkg::KIND_HEX;
                        r.output_value = top(0);
                        done = 1'b1;
                    end
                end else if (op == smp_pkg::OP_OUTSTR) begin
                    if (entries < 2) begin
                        st = smp_pkg::ST_FAIL;
                    end else begin
                        b = top(0);
                        r.output_kind = smp_pkg::KIND_STR;
                        r.output_value = top(1);
                        r.output_truncated = (b > 64'(slim));
                        r.output_length = r.output_truncated ? slim : b[15:0];
                        done = 1'b1;
                    end
                end else begin
                    st = smp_pkg::ST_FAIL;
                end
            end
            if (st == smp_pkg::ST_FAIL || st == smp_pkg::ST_OVER) halted = 1'b1;
            if (done) begin
                pc += jump;
                executed++;
                st = bounds();
                if (st != smp_pkg::ST_RUN) halted = 1'b1;
            end
            r.status = st;
            r.next_pc = pc[11:0];
            r.stack_count = 9'(entries);
            pending.insert(pending.size(), r);
        endfunction

        function bit check(smp_pkg::t_out got, output string why);
            smp_pkg::t_out e;
            why = "";
            if (pending.size() == 0) begin
                why = "result word with no expectation";
                return 1'b0;
            end
            e = pending.pop_front();
            if (got.status != e.status)
                why = {why, $sformatf(" status %0d/%0d", got.status, e.status)};
            if (got.next_pc != e.next_pc)
                why = {why, $sformatf(" next_pc %0d/%0d", got.next_pc, e.next_pc)};
            if (got.load_request != e.load_request)
                why = {why, $sformatf(" load_request %0d/%0d", got.load_request,
                                      e.load_request)};
            if (got.load_address != e.load_address)
                why = {why, $sformatf(" load_address %h/%h", got.load_address,
                                      e.load_address)};
            if (got.output_kind != e.output_kind)
                why = {why, $sformatf(" output_kind %0d/%0d", got.output_kind,
                                      e.output_kind)};
            if (got.output_value != e.output_value)
                why = {why, $sformatf(" output_value %h/%h", got.output_value,
                                      e.output_value)};
            if (got.output_length != e.output_length)
                why = {why, $sformatf(" output_length %0d/%0d", got.output_length,
                                      e.output_length)};
            if (got.output_truncated != e.output_truncated)
                why = {why, $sformatf(" output_truncated %0d/%0d",
                                      got.output_truncated, e.output_truncated)};
            if (got.stack_count != e.stack_count)
                why = {why, $sformatf(" stack_count %0d/%0d", got.stack_count,
                                      e.stack_count)};
            return why == "";
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 120;

    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    smp_pkg::t_in  i_in;
    logic          full;
    logic          pop;
    logic          empty;
    smp_pkg::t_out o_out;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [15:0]   i_cfg_data;

    smp_scoreboard sb;
    int            errors;
    int            idle_cycles;
    bit            calm;
    int            push_bias;

    stack_machine_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in        (i_in),
        .full        (full),
        .pop         (pop),
        .empty       (empty),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    function automatic smp_pkg::t_in mk(logic [4:0] op, logic [63:0] imm,
                                        logic [63:0] mem);
        smp_pkg::t_in it;
        it.opcode = op;
        it.immediate = imm;
        it.memory_word = mem;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_value();
        return ($urandom_range(0, 1) == 0) ? rand64() : 64'($urandom_range(0, 3));
    endfunction

    function automatic smp_pkg::t_in pick_word();
        int          r;
        logic [63:0] imm;
        if (sb.halted) begin
            if ($urandom_range(0, 9) != 0)
                return mk(smp_pkg::OP_START, rand_value(), rand64());
            return mk(5'($urandom_range(1, 31)), rand64(), rand64());
        end
        if (sb.await_load) begin
            if ($urandom_range(0, 9) != 0) return mk(smp_pkg::OP_LDRET, rand64(), rand64());
            return mk(5'($urandom_range(1, 31)), rand64(), rand64());
        end
        r = $urandom_range(0, 99);
        if (r < push_bias) return mk(smp_pkg::OP_PUSH, rand_value(), rand64());
        r = $urandom_range(0, 99);
        if (r < 3) return mk(smp_pkg::OP_START, rand_value(), rand64());
        if (r < 10) return mk(smp_pkg::OP_LDREQ, rand64(), rand64());
        if (r < 12) return mk(smp_pkg::OP_LDRET, rand64(), rand64());
        if (r < 45)
            return mk(5'($urandom_range(smp_pkg::OP_ADD, smp_pkg::OP_LE)), rand64(),
                      rand64());
        if (r < 55) begin
            imm = ($urandom_range(0, 15) == 0) ? rand64()
                                               : 64'($urandom_range(0, sb.entries + 1));
            return mk(smp_pkg::OP_COPY, imm, rand64());
        end
        if (r < 65) begin
            imm = ($urandom_range(0, 15) == 0) ? rand64() : 64'($urandom_range(0, 3));
            return mk(smp_pkg::OP_POP, imm, rand64());
        end
        if (r < 80) begin
            imm = ($urandom_range(0, 15) == 0) ? rand64()
                                               : 64'(signed'($urandom_range(0, 8)) - 4);
            return mk(($urandom_range(0, 1) == 0) ? smp_pkg::OP_JMP : smp_pkg::OP_CJMP,
                      imm, rand64());
        end
        if (r < 96)
            return mk(5'($urandom_range(smp_pkg::OP_OUTDEC, smp_pkg::OP_OUTSTR)), rand64(),
                      rand64());
        return mk(5'($urandom_range(27, 31)), rand64(), rand64());
    endfunction

    task automatic send_word(smp_pkg::t_in it);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note(it);
    endtask

    task automatic write_regs(logic [15:0] ilim, logic [15:0] slim, logic [15:0] plen);
        logic [15:0] vals [3];
        vals[0] = ilim;
        vals[1] = slim;
        vals[2] = plen;
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 2'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg(2'(i), vals[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(int count, int bias, bit last);
        push_bias = bias;
        for (int i = 0; i < count; i++) begin
            calm = last && (i >= count - 150);
            send_word(pick_word());
        end
    endtask

    initial begin
        int stall;
        string why;
        stall = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (!sb.check(o_out, why)) report(why);
            end
            if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(0, 8);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_stack_machine_step failed");
                $finish;
            end
        end
    end

    initial begin
        smp_pkg::t_in directed [$];
        sb = new();
        errors = 0;
        calm = 1'b0;
        push_bias = 20;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= smp_pkg::CFG_ILIM;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_regs(16'hFFFF, 16'd100, 16'd4096);
        directed = '{
            mk(smp_pkg::OP_START, '1, '0), mk(smp_pkg::OP_PUSH, '0, '1),
            mk(smp_pkg::OP_DIV, '0, '0), mk(smp_pkg::OP_START, 64'd5, '0),
            mk(smp_pkg::OP_PUSH, 64'h8000_0000_0000_0003, '0),
            mk(smp_pkg::OP_ADD, '0, '0), mk(smp_pkg::OP_SUB, '0, '0),
            mk(smp_pkg::OP_MUL, '0, '0), mk(smp_pkg::OP_DIV, '0, '0),
            mk(smp_pkg::OP_MOD, '0, '0), mk(smp_pkg::OP_AND, '0, '0),
            mk(smp_pkg::OP_OR, '0, '0), mk(smp_pkg::OP_XOR, '0, '0),
            mk(smp_pkg::OP_LAND, '0, '0), mk(smp_pkg::OP_LOR, '0, '0),
            mk(smp_pkg::OP_EQ, '0, '0), mk(smp_pkg::OP_NE, '0, '0),
            mk(smp_pkg::OP_GT, '0, '0), mk(smp_pkg::OP_GE, '0, '0),
            mk(smp_pkg::OP_LT, '0, '0), mk(smp_pkg::OP_LE, '0, '0),
            mk(smp_pkg::OP_COPY, 64'd2, '0), mk(smp_pkg::OP_POP, 64'd1, '0),
            mk(smp_pkg::OP_CJMP, 64'd4, '0), mk(smp_pkg::OP_JMP, '1, '0),
            mk(smp_pkg::OP_OUTDEC, '0, '0), mk(smp_pkg::OP_OUTHEX, '0, '0),
            mk(smp_pkg::OP_PUSH, 64'd2000, '0), mk(smp_pkg::OP_OUTSTR, '0, '0),
            mk(smp_pkg::OP_POP, '0, '0), mk(smp_pkg::OP_LDREQ, '0, '0),
            mk(smp_pkg::OP_LDRET, '0, '1), mk(smp_pkg::OP_LDRET, '0, '0),
            mk(5'd31, '1, '1)
        };
        foreach (directed[i]) send_word(directed[i]);
        drain();

        write_regs(smp_pkg::ILIM_RESET, smp_pkg::SLIM_RESET, 16'd0);
        run_random(30, 20, 1'b0);
        drain();
        write_regs(16'hFFFF, 16'hFFFF, 16'd4096);
        run_random(280, 20, 1'b0);
        drain();
        write_regs(16'd12, 16'd3, 16'd40);
        run_random(180, 20, 1'b0);
        drain();
        write_regs(16'd0, 16'd0, 16'd4096);
        run_random(40, 20, 1'b0);
        drain();
        write_regs(16'hFFFF, 16'd7, 16'd4096);
        run_random(330, 90, 1'b0);
        drain();
        write_regs(16'd300, smp_pkg::SLIM_RESET, 16'd200);
        run_random(220, 25, 1'b1);
        drain();

        if (sb.pending.size() != 0) report("expected result words left over");
        if (errors == 0) begin
            $display("tb_stack_machine_step passed");
        end else begin
            $display("tb_stack_machine_step failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/smp_pkg.sv
hw/rtl/smp_fifo.sv
hw/rtl/smp_muldiv.sv
hw/rtl/smp_front.sv
hw/rtl/smp_back.sv
hw/rtl/stack_machine_step.sv
tb/sv/tb_stack_machine_step.sv
